FILE: design/bba_pkg.sv
// Shared types, constants and helpers for the bitmap block allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package bba_pkg;

    // Fixed field widths
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int WSEL_W      = 3;
    localparam int PROD_W      = IDX_W + SIZE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int BCNT_W      = 8;

    // Divider: two quotient bits per cycle
    localparam int DIV_CYCLES  = ADDR_W / 2;
    localparam int DIVCNT_W    = 4;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0] RESET_BASE  = '0;
    localparam logic [BCNT_W-1:0] RESET_COUNT = 8'd64;
    localparam logic [SIZE_W-1:0] RESET_SIZE  = 16'd64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_NULL       = 3'd2,
        ST_BELOW      = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_BEYOND     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MUL,
        S_ADDR,
        S_DIV,
        S_FREE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    mul;
        logic    addr_sum;
        logic    div_init;
        logic    div_step;
        logic    free_eval;
        logic    reinit;
        logic    set_err;
        t_status err_code;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic addr_null;
        logic addr_below;
        logic scan_hit;
        logic scan_end;
        logic div_last;
    } t_dp_sts;

    // Free bits of bitmap word w when n blocks are active
    function automatic logic [WORD_BITS-1:0] fill_word(
        input logic [CNT_W-1:0]  n,
        input logic [WSEL_W-1:0] w
    );
        logic [CNT_W:0]          lo;
        logic [CNT_W:0]          hi;
        logic [CNT_W:0]          diff;
        logic [WORD_BITS-1:0]    mask;
        lo   = (CNT_W+1)'({w, {BIT_W{1'b0}}});
        hi   = lo + (CNT_W+1)'(WORD_BITS);
        diff = {1'b0, n} - lo;
        if ({1'b0, n} >= hi) begin
            mask = '1;
        end else if ({1'b0, n} <= lo) begin
            mask = '0;
        end else begin
            mask = (WORD_BITS'(1) << diff[BIT_W-1:0]) - WORD_BITS'(1);
        end
        return mask;
    endfunction

endpackage

FILE: design/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator.
// Instantiates bba_ctrl and bba_datapath; depends on bba_pkg.

// A command is taken when start is high and busy is low; its single result
// appears on o_status, o_granted_addr and o_granted_index, marked by o_done
// for exactly one cycle, and cannot be held off. A granted allocate runs the
// one-word-per-cycle scan, then the index multiply, then the base add; an
// allocate that finds no free block answers at the end of the scan; free
// answers from dispatch when the address is null or below base, and otherwise
// after the divider, which retires two quotient bits per cycle, and the free
// evaluation; reinit and the unused command answer from dispatch. busy falls
// in the o_done cycle, so the next command may start there. Configuration
// must be written by the user only while busy is low; the block itself does
// not enforce it.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_command,
    input  logic [ADDR_W-1:0]     i_block_addr,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [ADDR_W-1:0]     o_granted_addr,
    output logic [IDX_W-1:0]      o_granted_index
);

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;

    // Sequence each command
    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // Hold configuration, bitmap and arithmetic
    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_block_addr    (i_block_addr),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .o_status        (o_status),
        .o_granted_addr  (o_granted_addr),
        .o_granted_index (o_granted_index)
    );

endmodule

FILE: design/bba_datapath.sv
// Datapath of the bitmap block allocator: configuration registers, free bitmap,
// word scanner, index multiplier and radix-4 divider. Depends on bba_pkg.
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [1:0]            i_command,
    input  logic [ADDR_W-1:0]     i_block_addr,
    input  t_dp_cmd               i_ctl,
    output t_dp_sts               o_sts,
    output logic [2:0]            o_status,
    output logic [ADDR_W-1:0]     o_granted_addr,
    output logic [IDX_W-1:0]      o_granted_index
);

    localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_SEL_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [WORD_SEL_W-1:0] LAST_WORD = WORD_SEL_W'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] RESET_ACTIVE =
        ({1'b0, RESET_COUNT} > MAX_CNT) ? MAX_CNT : {1'b0, RESET_COUNT};

    // Configuration
    logic [ADDR_W-1:0]     r_base;
    logic [BCNT_W-1:0]     r_block_count;
    logic [SIZE_W-1:0]     r_block_size;

    // Free bitmap, a 1 marks a free block
    logic [WORD_BITS-1:0]  r_map [MAP_WORDS];

    // Request and work registers
    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic [WORD_SEL_W-1:0] r_word;
    logic [PROD_W-1:0]     r_prod;
    logic [ADDR_W-1:0]     r_quo;
    logic [SIZE_W-1:0]     r_rem;
    logic [DIVCNT_W-1:0]   r_div_cnt;

    // Result registers
    t_status               r_status;
    logic [ADDR_W-1:0]     r_gaddr;
    logic [IDX_W-1:0]      r_gidx;

    logic [CNT_W-1:0]      w_active;
    logic [SIZE_W-1:0]     w_eff_size;
    logic [ADDR_W-1:0]     w_off;
    logic [WORD_BITS-1:0]  w_cur;
    logic [BIT_W-1:0]      w_bit;
    logic                  w_hit;
    logic [CNT_W:0]        w_scan_hi;
    logic [SIZE_W:0]       w_t0;
    logic [SIZE_W:0]       w_t1;
    logic [SIZE_W-1:0]     w_rem0;
    logic [SIZE_W-1:0]     n_rem;
    logic                  w_q0;
    logic                  w_q1;
    logic [WORD_SEL_W-1:0] w_free_word;
    logic [BIT_W-1:0]      w_free_bit;
    logic                  w_free_ok;
    t_status               w_free_status;

    // Clamp the count and size as the pool defines them
    assign w_active   = ({1'b0, r_block_count} > MAX_CNT) ? MAX_CNT : {1'b0, r_block_count};
    assign w_eff_size = (r_block_size == '0) ? SIZE_W'(1) : r_block_size;
    assign w_off      = r_addr - r_base;

    // Scan: mask the current word to active blocks, find the lowest free bit
    assign w_cur = r_map[r_word] & fill_word(w_active, WSEL_W'(r_word));
    assign w_hit = |w_cur;
    assign w_scan_hi = (CNT_W+1)'({WSEL_W'(r_word), {BIT_W{1'b0}}}) + (CNT_W+1)'(WORD_BITS);

    always_comb begin
        w_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_cur[b]) begin
                w_bit = BIT_W'(b);
            end
        end
    end

    // Two restoring division steps per cycle
    always_comb begin
        w_t0   = {r_rem, r_quo[ADDR_W-1]};
        w_q0   = (w_t0 >= {1'b0, w_eff_size});
        w_rem0 = w_q0 ? SIZE_W'(w_t0 - {1'b0, w_eff_size}) : w_t0[SIZE_W-1:0];
        w_t1   = {w_rem0, r_quo[ADDR_W-2]};
        w_q1   = (w_t1 >= {1'b0, w_eff_size});
        n_rem  = w_q1 ? SIZE_W'(w_t1 - {1'b0, w_eff_size}) : w_t1[SIZE_W-1:0];
    end

    // Evaluate the divided offset of a free request
    assign w_free_word = r_quo[BIT_W +: WORD_SEL_W];
    assign w_free_bit  = r_quo[BIT_W-1:0];
    always_comb begin
        w_free_ok     = 1'b0;
        w_free_status = ST_OK;
        if (r_rem != '0) begin
            w_free_status = ST_MISALIGNED;
        end else if (r_quo >= ADDR_W'(w_active)) begin
            w_free_status = ST_BEYOND;
        end else begin
            w_free_ok = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= RESET_BASE;
            r_block_count <= RESET_COUNT;
            r_block_size  <= RESET_SIZE;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cfg_idx == CFG_COUNT) begin
                r_block_count <= i_cfg_wdata[BCNT_W-1:0];
            end
            if (i_cfg_idx == CFG_SIZE) begin
                r_block_size <= i_cfg_wdata[SIZE_W-1:0];
            end
        end
    end

    // Bitmap: fill on reset and reinit, clear on grant, set on free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= fill_word(RESET_ACTIVE, WSEL_W'(w));
            end
        end else if (i_ctl.reinit) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= fill_word(w_active, WSEL_W'(w));
            end
        end else if (i_ctl.scan && w_hit) begin
            r_map[r_word][w_bit] <= 1'b0;
        end else if (i_ctl.free_eval && w_free_ok) begin
            r_map[w_free_word][w_free_bit] <= 1'b1;
        end
    end

    // Request, scan pointer, multiplier and divider
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_addr <= i_block_addr;
            r_word <= '0;
        end
        if (i_ctl.scan && !w_hit) begin
            r_word <= r_word + WORD_SEL_W'(1);
        end
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(r_gidx) * PROD_W'(w_eff_size);
        end
        if (i_ctl.div_init) begin
            r_quo     <= w_off;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_ctl.div_step) begin
            r_quo     <= {r_quo[ADDR_W-3:0], w_q0, w_q1};
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + DIVCNT_W'(1);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_status <= ST_OK;
            r_gaddr  <= '0;
            r_gidx   <= '0;
        end
        if (i_ctl.set_err) begin
            r_status <= i_ctl.err_code;
        end
        if (i_ctl.scan && w_hit) begin
            r_gidx <= IDX_W'({WSEL_W'(r_word), w_bit});
        end
        if (i_ctl.addr_sum) begin
            r_gaddr <= r_base + ADDR_W'(r_prod);
        end
        if (i_ctl.free_eval) begin
            r_status <= w_free_status;
            if (w_free_ok) begin
                r_gidx <= r_quo[IDX_W-1:0];
            end
        end
    end

    // Status to the controller
    assign o_sts.cmd        = r_cmd;
    assign o_sts.addr_null  = (r_addr == '0);
    assign o_sts.addr_below = (r_addr < r_base);
    assign o_sts.scan_hit   = w_hit;
    assign o_sts.scan_end   = (r_word == LAST_WORD) || (w_scan_hi >= {1'b0, w_active});
    assign o_sts.div_last   = (r_div_cnt == DIVCNT_W'(DIV_CYCLES - 1));

    assign o_status        = r_status;
    assign o_granted_addr  = r_gaddr;
    assign o_granted_index = r_gidx;

endmodule

FILE: design/bba_ctrl.sv
// Controller of the bitmap block allocator: sequences allocate, free and
// reinit commands over the datapath. Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // State and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_ALLOC: begin
                        n_state = S_SCAN;
                    end
                    CMD_FREE: begin
                        priority if (i_sts.addr_null) begin
                            o_ctl.set_err  = 1'b1;
                            o_ctl.err_code = ST_NULL;
                            n_done         = 1'b1;
                            n_state        = S_IDLE;
                        end else if (i_sts.addr_below) begin
                            o_ctl.set_err  = 1'b1;
                            o_ctl.err_code = ST_BELOW;
                            n_done         = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_ctl.div_init = 1'b1;
                            n_state        = S_DIV;
                        end
                    end
                    CMD_REINIT: begin
                        o_ctl.reinit = 1'b1;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_NONE: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            // Walk the bitmap one word per cycle
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_MUL;
                end else if (i_sts.scan_end) begin
                    o_ctl.set_err  = 1'b1;
                    o_ctl.err_code = ST_NO_FREE;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                o_ctl.addr_sum = 1'b1;
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            // Divide the offset by the block size
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                o_ctl.free_eval = 1'b1;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

FILE: tb/bitmap_block_allocator_top_tb.sv
// Self-checking testbench for bitmap_block_allocator_top: directed and random
// allocate/free/reinit traffic, checked against an in-bench allocator model.
// Depends on bba_pkg and the design files under design/.
`timescale 1ns / 100ps

module bitmap_block_allocator_top_tb;
    import bba_pkg::*;

    localparam int MAP_WORDS = 256 / WORD_BITS;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  index;
    } t_grant;

    // Allocator model: holds its own copy of the registers and the free bitmap
    class grant_scoreboard;
        logic [ADDR_W-1:0]    base_addr;
        logic [BCNT_W-1:0]    blk_count;
        logic [SIZE_W-1:0]    blk_size;
        logic [WORD_BITS-1:0] free_map [MAP_WORDS];
        t_grant               pending_grants [$];
        int unsigned          errors;
        int unsigned          compared;

        function new();
            base_addr = RESET_BASE;
            blk_count = RESET_COUNT;
            blk_size  = RESET_SIZE;
            errors    = 0;
            compared  = 0;
            refill();
        endfunction

        function int unsigned unit_size();
            return (blk_size == 0) ? 1 : int'(blk_size);
        endfunction

        // Mark every block below the count free, all others taken
        function void refill();
            int unsigned n;
            int unsigned lo;
            n = blk_count;
            for (int w = 0; w < MAP_WORDS; w++) begin
                lo = w * WORD_BITS;
                if (n >= lo + WORD_BITS) begin
                    free_map[w] = '1;
                end else if (n <= lo) begin
                    free_map[w] = '0;
                end else begin
                    free_map[w] = (32'd1 << (n - lo)) - 32'd1;
                end
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE:  base_addr = data;
                CFG_COUNT: blk_count = data[BCNT_W-1:0];
                CFG_SIZE:  blk_size  = data[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the grant for one accepted command and queue it
        function void predict_grant(t_cmd cmd, logic [ADDR_W-1:0] addr);
            t_grant            g;
            int unsigned       n;
            logic [ADDR_W-1:0] off;
            logic [ADDR_W-1:0] quo;
            g.status = ST_OK;
            g.addr   = '0;
            g.index  = '0;
            n        = blk_count;
            case (cmd)
                CMD_ALLOC: begin
                    g.status = ST_NO_FREE;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (free_map[i / WORD_BITS][i % WORD_BITS]) begin
                            free_map[i / WORD_BITS][i % WORD_BITS] = 1'b0;
                            g.status = ST_OK;
                            g.index  = i[IDX_W-1:0];
                            g.addr   = base_addr + 32'(i) * 32'(unit_size());
                            break;
                        end
                    end
                end
                CMD_FREE: begin
                    off = addr - base_addr;
                    if (addr == 0) begin
                        g.status = ST_NULL;
                    end else if (addr < base_addr) begin
                        g.status = ST_BELOW;
                    end else if (off % unit_size() != 0) begin
                        g.status = ST_MISALIGNED;
                    end else begin
                        quo = off / unit_size();
                        if (quo >= n) begin
                            g.status = ST_BEYOND;
                        end else begin
                            free_map[quo / WORD_BITS][quo % WORD_BITS] = 1'b1;
                            g.index = quo[IDX_W-1:0];
                        end
                    end
                end
                CMD_REINIT: refill();
                default: ;
            endcase
            pending_grants.push_back(g);
        endfunction

        // Compare one result transfer with the oldest predicted grant
        function void check_grant(logic [2:0] st, logic [ADDR_W-1:0] ga,
                                  logic [IDX_W-1:0] gi);
            t_grant g;
            if (pending_grants.size() == 0) begin
                $error("result with no command outstanding: status %0d addr %h index %0d",
                       st, ga, gi);
                errors++;
                return;
            end
            g = pending_grants.pop_front();
            compared++;
            if (st !== g.status) begin
                $error("status: expected %0d, got %0d", g.status, st);
                errors++;
            end
            if (ga !== g.addr) begin
                $error("granted_addr: expected %h, got %h", g.addr, ga);
                errors++;
            end
            if (gi !== g.index) begin
                $error("granted_index: expected %0d, got %0d", g.index, gi);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_grants.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_command = '0;
    logic [ADDR_W-1:0]     i_block_addr = '0;
    logic                  o_done;
    logic [2:0]            o_status;
    logic [ADDR_W-1:0]     o_granted_addr;
    logic [IDX_W-1:0]      o_granted_index;

    grant_scoreboard       sb;
    int unsigned           cmd_tally [4];
    int unsigned           settings_run;

    bitmap_block_allocator_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_block_addr    (i_block_addr),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_addr  (o_granted_addr),
        .o_granted_index (o_granted_index)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && sb != null) begin
            sb.check_grant(o_status, o_granted_addr, o_granted_index);
        end
    end

    // Present one command, idling first at the given rate, and hold it until taken
    task automatic send_cmd(t_cmd cmd, logic [ADDR_W-1:0] addr, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_block_addr <= addr;
        do @(posedge i_clk); while (!(start && !busy));
        sb.predict_grant(cmd, addr);
        cmd_tally[cmd]++;
    endtask

    // Drop start and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [ADDR_W-1:0] base, logic [BCNT_W-1:0] cnt,
                             logic [SIZE_W-1:0] size);
        write_reg(CFG_BASE, base);
        write_reg(CFG_COUNT, ($urandom() & 32'hFFFF_FF00) | 32'(cnt));
        write_reg(CFG_SIZE, ($urandom() & 32'hFFFF_0000) | 32'(size));
        settings_run++;
    endtask

    // Free address: mostly in-range block addresses, the rest each kind of bad address or random
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int unsigned       sel;
        int unsigned       esz;
        int unsigned       idx;
        logic [ADDR_W-1:0] addr;
        sel = $urandom_range(99);
        esz = sb.unit_size();
        if (sel < 60) begin
            idx  = (sb.blk_count == 0) ? 0 : $urandom_range(sb.blk_count - 1);
            addr = sb.base_addr + 32'(idx * esz);
        end else if (sel < 70) begin
            idx  = sb.blk_count + $urandom_range(3);
            addr = sb.base_addr + 32'(idx * esz);
        end else if (sel < 80) begin
            idx  = $urandom_range(sb.blk_count);
            addr = sb.base_addr + 32'(idx * esz);
            if (esz > 1) begin
                addr = addr + $urandom_range(esz - 1, 1);
            end
        end else if (sel < 85) begin
            addr = sb.base_addr - $urandom_range(16, 1);
        end else if (sel < 90) begin
            addr = '0;
        end else begin
            addr = $urandom();
        end
        return addr;
    endfunction

    task automatic send_random(int unsigned alloc_pct, int unsigned reinit_pct,
                               int unsigned idle_pct);
        int unsigned sel;
        if ($urandom_range(99) < alloc_pct) begin
            send_cmd(CMD_ALLOC, $urandom(), idle_pct);
        end else begin
            sel = $urandom_range(99);
            if (sel < reinit_pct) begin
                send_cmd(CMD_REINIT, $urandom(), idle_pct);
            end else if (sel < reinit_pct + 3) begin
                send_cmd(CMD_NONE, $urandom(), idle_pct);
            end else begin
                send_cmd(CMD_FREE, pick_free_addr(), idle_pct);
            end
        end
    endtask

    // One register setting followed by random traffic
    task automatic run_phase(logic [ADDR_W-1:0] base, logic [BCNT_W-1:0] cnt,
                             logic [SIZE_W-1:0] size, int unsigned idle_pct,
                             int unsigned items, int unsigned alloc_pct,
                             int unsigned reinit_pct, bit fresh);
        drain();
        write_all(base, cnt, size);
        if (fresh) begin
            send_cmd(CMD_REINIT, '0, idle_pct);
        end
        repeat (items) send_random(alloc_pct, reinit_pct, idle_pct);
    endtask

    initial begin
        sb = new();
        settings_run = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: grants, double free, null, misaligned and beyond addresses, quotient overflow
        send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 0);
        send_cmd(CMD_ALLOC, 32'h0000_0000, 0);
        send_cmd(CMD_FREE, 32'd64, 0);
        send_cmd(CMD_FREE, 32'd64, 0);
        send_cmd(CMD_FREE, 32'd0, 0);
        send_cmd(CMD_NONE, 32'hFFFF_FFFF, 0);
        send_cmd(CMD_FREE, 32'd65, 0);
        send_cmd(CMD_FREE, 32'd4096, 0);
        send_cmd(CMD_FREE, 32'd16384, 0);
        send_cmd(CMD_FREE, 32'hFFFF_FFC0, 0);
        send_cmd(CMD_ALLOC, 32'h5555_5555, 0);

        // Zero block size and a shrunk count over a stale bitmap
        drain();
        write_all(32'h0000_1000, 8'd1, 16'd0);
        send_cmd(CMD_FREE, 32'h0000_0FFF, 0);
        send_cmd(CMD_ALLOC, 32'hAAAA_AAAA, 0);
        send_cmd(CMD_FREE, 32'h0000_1000, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_FREE, 32'h0000_1001, 0);
        send_cmd(CMD_REINIT, 32'hFFFF_FFFF, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);

        // Top of the address space: grants that wrap past 2^32
        drain();
        write_all(32'hFFFF_FFFF, 8'd255, 16'hFFFF);
        send_cmd(CMD_FREE, 32'hFFFF_FFFF, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_REINIT, 32'h0, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_ALLOC, 32'h0, 0);
        send_cmd(CMD_FREE, 32'h0000_FFFE, 0);

        // Random traffic over a spread of settings and idle rates
        run_phase(32'h0, 8'd32, 16'd64, 0, 100, 55, 5, 1);
        run_phase($urandom(), 8'd33, 16'd1, 73, 100, 55, 5, 1);
        run_phase(32'hFFFF_FF00, 8'd255, 16'hFFFF, 6, 300, 92, 0, 1);
        run_phase(32'h0, 8'd0, 16'd0, 0, 50, 50, 5, 1);
        run_phase($urandom(), 8'd1, 16'd3, 73, 80, 50, 8, 0);
        run_phase(32'hFFFF_FFFF, 8'd8, 16'd16, 6, 100, 55, 5, 1);
        run_phase($urandom(), 8'($urandom_range(255)), 16'($urandom_range(65535, 1)),
                  0, 100, 50, 5, 0);
        run_phase(32'h0001_0000, 8'd255, 16'd256, 73, 250, 90, 0, 1);
        run_phase($urandom(), 8'd64, 16'd7, 6, 100, 50, 5, 1);
        run_phase($urandom(), 8'($urandom_range(255, 100)), 16'($urandom_range(255, 1)),
                  73, 200, 60, 5, 0);

        // Let the last result land, then watch for strays
        drain();
        repeat (25) @(posedge i_clk);

        $display("Sent %0d allocate, %0d free, %0d reinit and %0d unused commands",
                 cmd_tally[CMD_ALLOC], cmd_tally[CMD_FREE], cmd_tally[CMD_REINIT],
                 cmd_tally[CMD_NONE]);
        $display("under %0d register settings; %0d results compared, %0d mismatches",
                 settings_run, sb.compared, sb.errors);
        if (sb.errors == 0) begin
            $display("** bitmap_block_allocator_top: PASSED **");
        end else begin
            $display("** bitmap_block_allocator_top: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("timeout: %0d results still outstanding",
                 (sb == null) ? 0 : sb.outstanding());
        $display("** bitmap_block_allocator_top: FAILED **");
        $finish;
    end

endmodule
